### rtl/ccms_pkg.sv
// ----------------------------------------------------------------------------
// ccms_pkg: shared types and constants for the chord match grader
// Widths, count limits and the grading constants in fixed point.
// ----------------------------------------------------------------------------
package ccms_pkg;

  // Pitch fields per chord and the note limit.
  localparam int SLOTS     = 4;
  localparam int MAX_NOTES = 4;
  localparam int NOTE_LIM  = (MAX_NOTES < SLOTS) ? MAX_NOTES : SLOTS;

  localparam int PITCH_W = 7;
  localparam int COUNT_W = 3;
  localparam int MASK_W  = 12;
  localparam int GRADE_W = 10;
  // Per-note partial grade, 0.6 times the distance grade (at most 600).
  localparam int PART_W  = 10;
  // Numerator 0.6*A + 400*B, at most 4000.
  localparam int NUM_W   = 12;

  localparam logic [GRADE_W-1:0] GRADE_EXACT = GRADE_W'(1000);
  localparam logic [GRADE_W-1:0] GRADE_CLASS = GRADE_W'(950);
  localparam logic [NUM_W-1:0]   CLASS_WT    = NUM_W'(400);

  // Floor division by three through a reciprocal: (x * 2731) >> 13, exact
  // for every numerator below 4096.
  localparam int DIV3_MUL   = 2731;
  localparam int DIV3_SHIFT = 13;

  // What one lane reports about its played note.
  typedef struct packed {
    logic [PART_W-1:0] part;   // 0.6 times the distance grade
    logic              exact;  // nearest distance is zero, or lane unused
    logic              hit;    // pitch class is in the event mask
  } lane_res_t;

endpackage

### rtl/chord_match_score.sv
// ----------------------------------------------------------------------------
// chord_match_score: grades a played chord against one score event
// Four note lanes feed a merge stage; one item per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Each transfer on the input channel yields exactly one result, held in the
// lane stage, then the output register. A new item is taken every cycle: the
// lane stage and the output register each hold one item, so the block keeps
// accepting while a finished result waits, and stalls its input only when
// both stages are full. The first stage holds four parallel lanes (one per
// played note), the second sums their reports and divides by the note count.
// ----------------------------------------------------------------------------
module chord_match_score (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ccms_pkg::PITCH_W-1:0] in_played_pitch_0,
  input  logic [ccms_pkg::PITCH_W-1:0] in_played_pitch_1,
  input  logic [ccms_pkg::PITCH_W-1:0] in_played_pitch_2,
  input  logic [ccms_pkg::PITCH_W-1:0] in_played_pitch_3,
  input  logic [ccms_pkg::COUNT_W-1:0] in_played_count,
  input  logic [ccms_pkg::PITCH_W-1:0] in_score_pitch_0,
  input  logic [ccms_pkg::PITCH_W-1:0] in_score_pitch_1,
  input  logic [ccms_pkg::PITCH_W-1:0] in_score_pitch_2,
  input  logic [ccms_pkg::PITCH_W-1:0] in_score_pitch_3,
  input  logic [ccms_pkg::COUNT_W-1:0] in_score_count,
  input  logic [ccms_pkg::MASK_W-1:0]  in_score_class_mask,
  input  logic                         in_event_valid,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ccms_pkg::GRADE_W-1:0] out_match_grade,
  output logic                         out_no_event
);

  logic [ccms_pkg::PITCH_W-1:0] played [ccms_pkg::SLOTS];
  logic [ccms_pkg::PITCH_W-1:0] score  [ccms_pkg::SLOTS];
  logic [ccms_pkg::COUNT_W-1:0] np_clamp;
  logic [ccms_pkg::COUNT_W-1:0] ns_clamp;
  ccms_pkg::lane_res_t          lane_res [ccms_pkg::SLOTS];

  logic                         s1_valid_r;
  ccms_pkg::lane_res_t          lane_res_r [ccms_pkg::SLOTS];
  logic [ccms_pkg::COUNT_W-1:0] np_r;
  logic                         evt_r;

  logic                         out_valid_r;
  logic [ccms_pkg::GRADE_W-1:0] grade_r;
  logic                         no_event_r;
  logic [ccms_pkg::GRADE_W-1:0] grade_nxt;
  logic                         no_event_nxt;

  logic                         out_en;
  logic                         s1_en;

  assign played[0] = in_played_pitch_0;
  assign played[1] = in_played_pitch_1;
  assign played[2] = in_played_pitch_2;
  assign played[3] = in_played_pitch_3;
  assign score[0]  = in_score_pitch_0;
  assign score[1]  = in_score_pitch_1;
  assign score[2]  = in_score_pitch_2;
  assign score[3]  = in_score_pitch_3;

  // Counts above the note limit saturate; extra notes are dropped.
  assign np_clamp = (in_played_count > ccms_pkg::COUNT_W'(ccms_pkg::NOTE_LIM))
                  ? ccms_pkg::COUNT_W'(ccms_pkg::NOTE_LIM) : in_played_count;
  assign ns_clamp = (in_score_count > ccms_pkg::COUNT_W'(ccms_pkg::NOTE_LIM))
                  ? ccms_pkg::COUNT_W'(ccms_pkg::NOTE_LIM) : in_score_count;

  // One lane per played note.
  for (genvar i = 0; i < ccms_pkg::SLOTS; i++) begin : g_lane
    ccms_lane u_lane (
      .played_pitch (played[i]),
      .active       (ccms_pkg::COUNT_W'(i) < np_clamp),
      .score_pitch  (score),
      .score_count  (ns_clamp),
      .class_mask   (in_score_class_mask),
      .res          (lane_res[i])
    );
  end

  // Stage enables: a stage moves when it is empty or its successor moves.
  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;

  // Lane stage registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      lane_res_r <= lane_res;
      np_r       <= np_clamp;
      evt_r      <= in_event_valid;
    end
  end

  // Merge of the lane reports.
  ccms_merge u_merge (
    .lanes        (lane_res_r),
    .played_count (np_r),
    .event_valid  (evt_r),
    .match_grade  (grade_nxt),
    .no_event     (no_event_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      grade_r    <= grade_nxt;
      no_event_r <= no_event_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_grade = grade_r;
  assign out_no_event    = no_event_r;

endmodule

### rtl/ccms_lane.sv
// ----------------------------------------------------------------------------
// ccms_lane: grades one played note against the score event
// Finds the nearest score pitch, maps the distance to a partial grade and
// tests the note's pitch class against the event mask.
// ----------------------------------------------------------------------------
module ccms_lane (
  input  logic [ccms_pkg::PITCH_W-1:0] played_pitch,
  input  logic                         active,
  input  logic [ccms_pkg::PITCH_W-1:0] score_pitch [ccms_pkg::SLOTS],
  input  logic [ccms_pkg::COUNT_W-1:0] score_count,
  input  logic [ccms_pkg::MASK_W-1:0]  class_mask,
  output ccms_pkg::lane_res_t          res
);

  // Distance grade scaled by 0.6: 0, 1, 2, 3 map to 600, 540, 480, 360.
  function automatic logic [ccms_pkg::PART_W-1:0] dist_part(
    input logic [ccms_pkg::PITCH_W:0] d
  );
    logic [ccms_pkg::PART_W-1:0] p;
    begin
      case (d)
        8'd0:    p = ccms_pkg::PART_W'(600);
        8'd1:    p = ccms_pkg::PART_W'(540);
        8'd2:    p = ccms_pkg::PART_W'(480);
        8'd3:    p = ccms_pkg::PART_W'(360);
        default: p = '0;
      endcase
      return p;
    end
  endfunction

  logic [ccms_pkg::PITCH_W:0]   pdist [ccms_pkg::SLOTS];
  logic [ccms_pkg::PITCH_W:0]   best;
  logic                         found;
  logic [3:0]                   quot12;
  logic [12:0]                  prod12;
  logic [ccms_pkg::PITCH_W-1:0] q_times12;
  logic [ccms_pkg::PITCH_W-1:0] rem12;

  // Distance to each valid score pitch; unused slots read as the maximum.
  always_comb begin
    for (int j = 0; j < ccms_pkg::SLOTS; j++) begin
      if (ccms_pkg::COUNT_W'(j) < score_count) begin
        pdist[j] = (played_pitch > score_pitch[j])
                 ? {1'b0, played_pitch - score_pitch[j]}
                 : {1'b0, score_pitch[j] - played_pitch};
      end else begin
        pdist[j] = '1;
      end
    end
  end

  // Running minimum over the score slots.
  always_comb begin
    best = pdist[0];
    for (int j = 1; j < ccms_pkg::SLOTS; j++) begin
      if (pdist[j] < best) begin
        best = pdist[j];
      end
    end
  end

  assign found = (score_count != '0);

  // Pitch class: pitch mod 12, with the quotient taken as (p * 43) >> 9.
  assign prod12    = 13'(played_pitch) * 13'd43;
  assign quot12    = prod12[12:9];
  assign q_times12 = {quot12, 3'b000} + {1'b0, quot12, 2'b00};
  assign rem12     = played_pitch - q_times12;

  // An unused lane adds nothing and does not spoil the exact-match test.
  always_comb begin
    if (active) begin
      res.part  = found ? dist_part(best) : '0;
      res.exact = found && (best == '0);
      res.hit   = class_mask[rem12[3:0]];
    end else begin
      res.part  = '0;
      res.exact = 1'b1;
      res.hit   = 1'b0;
    end
  end

endmodule

### rtl/ccms_merge.sv
// ----------------------------------------------------------------------------
// ccms_merge: combines the lane reports into the match grade
// Sums the partial grades and class hits, then picks a zero grade (no event or
// no notes) or the exact, class or averaged grade, dividing by the note count.
// ----------------------------------------------------------------------------
module ccms_merge (
  input  ccms_pkg::lane_res_t           lanes [ccms_pkg::SLOTS],
  input  logic [ccms_pkg::COUNT_W-1:0]  played_count,
  input  logic                          event_valid,
  output logic [ccms_pkg::GRADE_W-1:0]  match_grade,
  output logic                          no_event
);

  logic [ccms_pkg::NUM_W-1:0]   part_sum;
  logic [ccms_pkg::COUNT_W-1:0] hit_cnt;
  logic                         all_exact;
  logic [ccms_pkg::NUM_W-1:0]   numer;
  logic [2*ccms_pkg::NUM_W-1:0] div3_prod;
  logic [ccms_pkg::NUM_W-1:0]   quot;

  // Reduce the lanes.
  always_comb begin
    part_sum  = '0;
    hit_cnt   = '0;
    all_exact = 1'b1;
    for (int i = 0; i < ccms_pkg::SLOTS; i++) begin
      part_sum  = part_sum + ccms_pkg::NUM_W'(lanes[i].part);
      hit_cnt   = hit_cnt + ccms_pkg::COUNT_W'(lanes[i].hit);
      all_exact = all_exact & lanes[i].exact;
    end
  end

  assign numer     = part_sum + ccms_pkg::NUM_W'(hit_cnt) * ccms_pkg::CLASS_WT;
  assign div3_prod = (2*ccms_pkg::NUM_W)'(numer)
                   * (2*ccms_pkg::NUM_W)'(ccms_pkg::DIV3_MUL);

  // Divide the numerator by the note count (one to four).
  always_comb begin
    case (played_count)
      3'd2:    quot = numer >> 1;
      3'd3:    quot = ccms_pkg::NUM_W'(div3_prod >> ccms_pkg::DIV3_SHIFT);
      3'd4:    quot = numer >> 2;
      default: quot = numer;
    endcase
  end

  // Final selection between the special cases and the averaged grade.
  always_comb begin
    no_event = 1'b0;
    if (!event_valid) begin
      match_grade = '0;
      no_event    = 1'b1;
    end else if (played_count == '0) begin
      match_grade = '0;
    end else if (all_exact) begin
      match_grade = ccms_pkg::GRADE_EXACT;
    end else if (hit_cnt == played_count) begin
      match_grade = ccms_pkg::GRADE_CLASS;
    end else begin
      match_grade = quot[ccms_pkg::GRADE_W-1:0];
    end
  end

endmodule

### rtl/chord_match_score_chk.sv
// ----------------------------------------------------------------------------
// chord_match_score_chk: port-level checks for the chord match grader
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module chord_match_score_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [ccms_pkg::GRADE_W-1:0] out_match_grade,
  input logic                         out_no_event
);

  // The output is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // The input only stalls when a finished result is held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A missing event always carries a zero grade.
  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_event) |-> (out_match_grade == '0))
    else $error("grade set on a result without an event");

  // The grade never exceeds a full match.
  a_grade_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_grade <= ccms_pkg::GRADE_EXACT))
    else $error("grade above full match");

  // A stalled result holds until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_match_grade) && $stable(out_no_event)))
    else $error("stalled result changed");

endmodule

bind chord_match_score chord_match_score_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_match_grade (out_match_grade),
  .out_no_event    (out_no_event)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the chord match grader
// A queue of chords, a directed set first and then random ones built around
// each score event, feeds a clocked driver. A clocked monitor compares every
// result with the grade worked out by an in-bench predictor. Both sides idle
// in random bursts, and the receiver holds off once long enough to fill the
// block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int N_RANDOM     = 1700;
  localparam int CALM_TAIL    = 150;     // last chords are sent with no idling
  localparam int HOLD_AFTER   = 300;     // results checked before the long hold
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  // Per-note grades for nearest distances 0 to 3; larger distances give zero.
  localparam int NOTE_GRADE_D0 = 1000;
  localparam int NOTE_GRADE_D1 = 900;
  localparam int NOTE_GRADE_D2 = 800;
  localparam int NOTE_GRADE_D3 = 600;
  localparam int GRADE_ALL_EXACT = 1000;
  localparam int GRADE_ALL_CLASS = 950;

  typedef struct packed {
    logic [ccms_pkg::SLOTS-1:0][ccms_pkg::PITCH_W-1:0] played;
    logic [ccms_pkg::COUNT_W-1:0]                      played_count;
    logic [ccms_pkg::SLOTS-1:0][ccms_pkg::PITCH_W-1:0] score;
    logic [ccms_pkg::COUNT_W-1:0]                      score_count;
    logic [ccms_pkg::MASK_W-1:0]                       class_mask;
    logic                                              event_valid;
  } chord_t;

  typedef struct packed {
    logic [ccms_pkg::GRADE_W-1:0] grade;
    logic                         no_event;
  } grade_t;

  logic                         clk;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ccms_pkg::GRADE_W-1:0] out_match_grade;
  logic                         out_no_event;
  chord_t                       drv_chord = '0;

  chord_t pending_chords[$];
  grade_t expected_grades[$];

  int send_gap   = 0;
  int recv_gap   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int cycle_cnt  = 0;
  int n_sent     = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_no_event = 0;
  int n_exact    = 0;
  int n_class    = 0;

  chord_match_score i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_played_pitch_0   (drv_chord.played[0]),
    .in_played_pitch_1   (drv_chord.played[1]),
    .in_played_pitch_2   (drv_chord.played[2]),
    .in_played_pitch_3   (drv_chord.played[3]),
    .in_played_count     (drv_chord.played_count),
    .in_score_pitch_0    (drv_chord.score[0]),
    .in_score_pitch_1    (drv_chord.score[1]),
    .in_score_pitch_2    (drv_chord.score[2]),
    .in_score_pitch_3    (drv_chord.score[3]),
    .in_score_count      (drv_chord.score_count),
    .in_score_class_mask (drv_chord.class_mask),
    .in_event_valid      (drv_chord.event_valid),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_match_grade     (out_match_grade),
    .out_no_event        (out_no_event)
  );

  // Expected grade of one chord against one score event.
  function automatic grade_t grade_chord(chord_t c);
    grade_t r;
    int     np;
    int     ns;
    int     best;
    int     d;
    int     sum_a;
    int     hits;
    bit     found;
    bit     all_exact;
    r         = '0;
    sum_a     = 0;
    hits      = 0;
    all_exact = 1'b1;
    np = (int'(c.played_count) > ccms_pkg::NOTE_LIM)
       ? ccms_pkg::NOTE_LIM : int'(c.played_count);
    ns = (int'(c.score_count) > ccms_pkg::NOTE_LIM)
       ? ccms_pkg::NOTE_LIM : int'(c.score_count);
    if (!c.event_valid) begin
      r.no_event = 1'b1;
      return r;
    end
    if (np == 0) return r;
    for (int i = 0; i < np; i++) begin
      found = 1'b0;
      best  = 0;
      for (int j = 0; j < ns; j++) begin
        d = int'(c.played[i]) - int'(c.score[j]);
        if (d < 0) d = -d;
        if (!found || d < best) begin
          best  = d;
          found = 1'b1;
        end
      end
      if (found) begin
        case (best)
          0: sum_a += NOTE_GRADE_D0;
          1: sum_a += NOTE_GRADE_D1;
          2: sum_a += NOTE_GRADE_D2;
          3: sum_a += NOTE_GRADE_D3;
          default: ;
        endcase
        if (best != 0) all_exact = 1'b0;
      end else begin
        all_exact = 1'b0;
      end
      if (c.class_mask[int'(c.played[i]) % 12]) hits++;
    end
    if (all_exact) r.grade = ccms_pkg::GRADE_W'(GRADE_ALL_EXACT);
    else if (hits == np) r.grade = ccms_pkg::GRADE_W'(GRADE_ALL_CLASS);
    else r.grade = ccms_pkg::GRADE_W'((6 * sum_a + 4000 * hits) / (10 * np));
    return r;
  endfunction

  // Pitch at a random offset of up to spread from center, kept in MIDI range.
  function automatic logic [ccms_pkg::PITCH_W-1:0] near_pitch(int center, int spread);
    int p;
    p = center + $urandom_range(0, 2 * spread) - spread;
    if (p < 0) p = 0;
    if (p > 127) p = 127;
    return ccms_pkg::PITCH_W'(p);
  endfunction

  task automatic add_chord(int p0, int p1, int p2, int p3, int pc,
                           int s0, int s1, int s2, int s3, int sc,
                           int mask, int ev);
    chord_t c;
    c.played       = {ccms_pkg::PITCH_W'(p3), ccms_pkg::PITCH_W'(p2),
                      ccms_pkg::PITCH_W'(p1), ccms_pkg::PITCH_W'(p0)};
    c.played_count = ccms_pkg::COUNT_W'(pc);
    c.score        = {ccms_pkg::PITCH_W'(s3), ccms_pkg::PITCH_W'(s2),
                      ccms_pkg::PITCH_W'(s1), ccms_pkg::PITCH_W'(s0)};
    c.score_count  = ccms_pkg::COUNT_W'(sc);
    c.class_mask   = ccms_pkg::MASK_W'(mask);
    c.event_valid  = ev[0];
    pending_chords.insert(pending_chords.size(), c);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stimulus, reset, and the end of the run.
  initial begin
    chord_t c;
    int     kind;
    int     base;
    int     ns;
    int     j;
    // Directed part: no event, empty chord, each distance, class-only match,
    // oversized counts, empty score event and pitch extremes.
    add_chord(60, 64, 67, 72, 4, 60, 64, 67, 72, 4, 'h091, 0);
    add_chord(127, 127, 127, 127, 7, 0, 0, 0, 0, 0, 'hFFF, 0);
    add_chord(60, 64, 67, 72, 0, 60, 64, 67, 72, 4, 'h091, 1);
    add_chord(60, 64, 67, 72, 4, 60, 64, 67, 72, 4, 'h091, 1);
    add_chord(0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 'h001, 1);
    add_chord(127, 0, 0, 0, 1, 127, 0, 0, 0, 1, 'h080, 1);
    add_chord(61, 0, 0, 0, 1, 60, 0, 0, 0, 1, 'h000, 1);
    add_chord(62, 0, 0, 0, 1, 60, 0, 0, 0, 1, 'h000, 1);
    add_chord(63, 0, 0, 0, 1, 60, 0, 0, 0, 1, 'h000, 1);
    add_chord(64, 0, 0, 0, 1, 60, 0, 0, 0, 1, 'h000, 1);
    add_chord(48, 0, 0, 0, 1, 60, 0, 0, 0, 1, 'h001, 1);
    add_chord(60, 62, 70, 0, 3, 60, 64, 67, 0, 3, 'h091, 1);
    add_chord(61, 65, 68, 73, 4, 60, 64, 67, 72, 4, 'h091, 1);
    add_chord(60, 64, 67, 72, 7, 60, 64, 67, 72, 5, 'h091, 1);
    add_chord(60, 63, 67, 71, 6, 59, 64, 66, 72, 7, 'h8D1, 1);
    add_chord(60, 64, 67, 72, 5, 60, 64, 67, 72, 6, 'h000, 1);
    add_chord(60, 64, 67, 72, 4, 0, 0, 0, 0, 0, 'hFFF, 1);
    add_chord(60, 64, 67, 72, 4, 0, 0, 0, 0, 0, 'h000, 1);
    add_chord(0, 127, 0, 127, 4, 127, 0, 127, 0, 1, 'h000, 1);
    add_chord(0, 127, 0, 127, 2, 127, 0, 127, 0, 2, 'hFFF, 1);
    add_chord(127, 127, 127, 127, 4, 124, 125, 126, 127, 4, 'hF00, 1);

    // Random part: mostly score events with played notes close to them.
    for (int k = 0; k < N_RANDOM; k++) begin
      c    = '0;
      kind = $urandom_range(0, 99);
      c.event_valid  = (kind >= 6);
      c.score_count  = ($urandom_range(0, 11) == 0)
                     ? ccms_pkg::COUNT_W'($urandom_range(0, 7))
                     : ccms_pkg::COUNT_W'($urandom_range(1, 4));
      c.played_count = ($urandom_range(0, 11) == 0)
                     ? ccms_pkg::COUNT_W'($urandom_range(0, 7))
                     : ccms_pkg::COUNT_W'($urandom_range(1, 4));
      base = $urandom_range(0, 127);
      for (int s = 0; s < ccms_pkg::SLOTS; s++) begin
        c.score[s] = (kind < 20) ? ccms_pkg::PITCH_W'($urandom_range(0, 127))
                                 : near_pitch(base, 9);
      end
      ns = (int'(c.score_count) > ccms_pkg::NOTE_LIM)
         ? ccms_pkg::NOTE_LIM : int'(c.score_count);
      if ($urandom_range(0, 6) == 0) begin
        c.class_mask = ccms_pkg::MASK_W'($urandom_range(0, 4095));
      end else begin
        for (int s = 0; s < ns; s++) c.class_mask[int'(c.score[s]) % 12] = 1'b1;
        if ($urandom_range(0, 3) == 0) c.class_mask[$urandom_range(0, 11)] ^= 1'b1;
      end
      for (int p = 0; p < ccms_pkg::SLOTS; p++) begin
        j = $urandom_range(0, ccms_pkg::SLOTS - 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: c.played[p] = c.score[j];
          4, 5, 6:    c.played[p] = near_pitch(int'(c.score[j]), 4);
          7:          c.played[p] = near_pitch(int'(c.score[j]) + 12, 1);
          default:    c.played[p] = ccms_pkg::PITCH_W'($urandom_range(0, 127));
        endcase
      end
      pending_chords.insert(pending_chords.size(), c);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_chords.size() > 0 || in_valid || expected_grades.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Graded %0d chords: %0d with no event, %0d exact, %0d with every class found.",
             n_checked, n_no_event, n_exact, n_class);
    $display("Receiver held off once for %0d cycles; %0d mismatches seen.",
             HOLD_CYCLES, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Driver: records each transfer and presents the next chord or a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_grades.insert(expected_grades.size(), grade_chord(drv_chord));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_chords.size() > 0) begin
          drv_chord <= pending_chords.pop_front();
          in_valid  <= 1'b1;
          // Keep offering during the long hold so the block fills up.
          if (pending_chords.size() >= CALM_TAIL && hold_left == 0 &&
              $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 18);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, started once a few hundred results have been checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_checked >= HOLD_AFTER) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end
  end

  // Monitor: checks each result transfer and drives the receiver stall.
  always @(posedge clk) begin
    grade_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_grades.size() == 0) begin
          $error("unexpected result: match_grade %0d, no_event %0b",
                 out_match_grade, out_no_event);
          n_errors++;
        end else begin
          want = expected_grades.pop_front();
          if (out_match_grade !== want.grade) begin
            $error("match_grade mismatch: expected %0d, actual %0d",
                   want.grade, out_match_grade);
            n_errors++;
          end
          if (out_no_event !== want.no_event) begin
            $error("no_event mismatch: expected %0b, actual %0b",
                   want.no_event, out_no_event);
            n_errors++;
          end
          n_checked++;
          if (want.no_event) n_no_event++;
          if (want.grade == ccms_pkg::GRADE_W'(GRADE_ALL_EXACT)) n_exact++;
          if (want.grade == ccms_pkg::GRADE_W'(GRADE_ALL_CLASS)) n_class++;
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (pending_chords.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d chords sent.", cycle_cnt, n_sent);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
